// ===== rtl/mtrb_pkg.sv =====
// Shared constants, types and state encoding for the max-tree row builder.
// No dependencies; imported by every module of the block.
package mtrb_pkg;

  // Row bound and pixel depth
  localparam int LINE_MAX   = 64;
  localparam int PIXEL_BITS = 8;

  // Derived widths
  localparam int COL_W   = $clog2(LINE_MAX);
  localparam int CNT_W   = $clog2(LINE_MAX + 1);
  localparam int LVL_W   = PIXEL_BITS;
  localparam int ENTRY_W = COL_W + LVL_W;

  // Fixed field widths of the channels
  localparam int PIX_IN_W = 8;
  localparam int NODE_W   = 6;
  localparam int GLOB_W   = 32;
  localparam int BASE_W   = 31;
  localparam int PITCH_W  = 16;
  localparam int ROW_W    = 16;
  localparam int CFG_W    = 31;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH   = 1'd1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_CHAIN,
    ST_EQ2,
    ST_FLUSH,
    ST_FCHAIN,
    ST_FINISH
  } mtrb_state_e;

  // Stack operation request from the sequencer
  typedef struct packed {
    logic             push;
    logic             pop;
    logic             clear;
    logic [COL_W-1:0] col;
    logic [LVL_W-1:0] lvl;
  } stack_cmd_t;

  // Stack status back to the sequencer
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [COL_W-1:0] top_col;
    logic [LVL_W-1:0] top_lvl;
  } stack_stat_t;

endpackage

// ===== rtl/mtrb_stack.sv =====
// Level-root stack: one synchronous memory plus a cached top entry.
// Depends on mtrb_pkg for widths and the command/status structs.
module mtrb_stack (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mtrb_pkg::stack_cmd_t cmd_i,
  output mtrb_pkg::stack_stat_t stat_o
);
  import mtrb_pkg::*;

  logic [ENTRY_W-1:0] mem [LINE_MAX];
  logic [ENTRY_W-1:0] rdata_q;
  logic               refill_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [COL_W-1:0]   top_col_q, top_col_d;
  logic [LVL_W-1:0]   top_lvl_q, top_lvl_d;
  logic [CNT_W-1:0]   below_top;
  logic [COL_W-1:0]   rd_addr;

  // Entry under the current top, which becomes the top after a pop
  assign below_top = count_q - CNT_W'(2);
  assign rd_addr   = below_top[COL_W-1:0];

  // Write on push, read the next top on pop
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[count_q[COL_W-1:0]] <= {cmd_i.col, cmd_i.lvl};
    end
    if (cmd_i.pop) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Forward the freshly read entry as the top in the cycle after a pop
  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CNT_W'(1);
    end

    if (cmd_i.push) begin
      top_col_d = cmd_i.col;
      top_lvl_d = cmd_i.lvl;
    end else if (refill_q) begin
      top_col_d = rdata_q[ENTRY_W-1:LVL_W];
      top_lvl_d = rdata_q[LVL_W-1:0];
    end else begin
      top_col_d = top_col_q;
      top_lvl_d = top_lvl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      refill_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      refill_q <= cmd_i.pop && (count_q > CNT_W'(1));
    end
  end

  // Top cache holds payload only
  always_ff @(posedge clk_i) begin
    top_col_q <= top_col_d;
    top_lvl_q <= top_lvl_d;
  end

  assign stat_o.count   = count_q;
  assign stat_o.top_col = refill_q ? rdata_q[ENTRY_W-1:LVL_W] : top_col_q;
  assign stat_o.top_lvl = refill_q ? rdata_q[LVL_W-1:0] : top_lvl_q;

endmodule

// ===== rtl/max_tree_row_builder.sv =====
// Max-tree row builder: sequencer, configuration, global index and output item.
// Depends on mtrb_pkg and mtrb_stack.
//
// Usage:
//   Pixels enter on the in channel (pixel_i, last_pixel_i) with valid/ready.
//   Parent links leave on the out channel, one item per link, the last item
//   caused by a pixel marked with last_of_run_o. A pixel that only opens a new
//   level root produces no item. Configuration (base offset, row pitch) is
//   written through cfg_we_i; the user must write it only while the block is
//   idle, which the block does not enforce. in_ready_o stays low while a write
//   is offered and in the next cycle, while the row offset product settles.
// Timing:
//   One item is worked on at a time. A pixel passes through accept, decide
//   and finish, with a ST_CHAIN step per root unstacked, an ST_EQ2 step when
//   the unstack ends on an equal-level root, and on a row flush ST_FLUSH then
//   an ST_FCHAIN step per stacked root. Each unstack is one read of the stack
//   memory, whose registered read data is forwarded as the new top in the
//   next cycle.
// Reset and stalls:
//   Reset empties the stack and clears column, row and configuration. The
//   stack memory needs no clearing pass. A stalled receiver holds the output
//   register and the sequencer waits on it; no item is lost.
module max_tree_row_builder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mtrb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mtrb_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mtrb_pkg::PIX_IN_W-1:0]  pixel_i,
  input  logic                           last_pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mtrb_pkg::NODE_W-1:0]    node_column_o,
  output logic [mtrb_pkg::GLOB_W-1:0]    parent_global_o,
  output logic                           is_root_o,
  output logic                           overflow_error_o,
  output logic                           last_of_run_o
);
  import mtrb_pkg::*;

  mtrb_state_e      state_q, state_d;
  stack_cmd_t       cmd;
  stack_stat_t      stat;

  logic [BASE_W-1:0]  base_q;
  logic [PITCH_W-1:0] pitch_q;
  logic [ROW_W-1:0]   row_q;
  logic [GLOB_W-1:0]  prod_q;
  logic               cfg_seen_q;
  logic [CNT_W-1:0]   col_q;

  logic [LVL_W-1:0] pix_q;
  logic             last_q;
  logic             ovf_q;
  logic [COL_W-1:0] icol_q;
  logic [COL_W-1:0] r_q, r_d;

  logic             accept;
  logic             out_free;
  logic             em_go;
  logic [COL_W-1:0] em_node;
  logic [COL_W-1:0] em_pcol;
  logic             em_root;
  logic             em_zero;
  logic             em_last;
  logic [GLOB_W-1:0] em_parent;

  logic              out_valid_q;
  logic [NODE_W-1:0] out_node_q;
  logic [GLOB_W-1:0] out_parent_q;
  logic              out_root_q;
  logic              out_err_q;
  logic              out_last_q;

  mtrb_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  // Take a pixel only when idle and the row offset product is settled
  assign in_ready_o = (state_q == ST_IDLE) && !cfg_we_i && !cfg_seen_q;
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Sequencer: next state, stack operations and result generation
  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    cmd     = '0;
    cmd.col = icol_q;
    cmd.lvl = pix_q;
    em_go   = 1'b0;
    em_node = '0;
    em_pcol = '0;
    em_root = 1'b0;
    em_zero = 1'b0;
    em_last = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_STEP;
        end
      end

      ST_STEP: begin
        if (ovf_q) begin
          // Dropped pixel: flush if row ends, else report the error alone
          if (last_q) begin
            state_d = ST_FLUSH;
          end else if (out_free) begin
            em_go   = 1'b1;
            em_zero = 1'b1;
            em_last = 1'b1;
            state_d = ST_FINISH;
          end
        end else if (stat.count == '0 || stat.top_lvl < pix_q) begin
          cmd.push = 1'b1;
          state_d  = last_q ? ST_FLUSH : ST_FINISH;
        end else if (stat.top_lvl == pix_q) begin
          if (out_free) begin
            em_go   = 1'b1;
            em_node = icol_q;
            em_pcol = stat.top_col;
            em_last = !last_q;
            state_d = last_q ? ST_FLUSH : ST_FINISH;
          end
        end else begin
          r_d     = stat.top_col;
          cmd.pop = 1'b1;
          state_d = ST_CHAIN;
        end
      end

      ST_CHAIN: begin
        if (stat.count != '0 && stat.top_lvl > pix_q) begin
          // Link the unstacked root to the next lower root
          if (out_free) begin
            em_go   = 1'b1;
            em_node = r_q;
            em_pcol = stat.top_col;
            r_d     = stat.top_col;
            cmd.pop = 1'b1;
          end
        end else if (stat.count == '0 || stat.top_lvl < pix_q) begin
          // New pixel becomes the parent and a new level root
          if (out_free) begin
            em_go    = 1'b1;
            em_node  = r_q;
            em_pcol  = icol_q;
            em_last  = !last_q;
            cmd.push = 1'b1;
            state_d  = last_q ? ST_FLUSH : ST_FINISH;
          end
        end else if (out_free) begin
          // Equal-level root found: link unstacked root first
          em_go   = 1'b1;
          em_node = r_q;
          em_pcol = stat.top_col;
          state_d = ST_EQ2;
        end
      end

      ST_EQ2: begin
        if (out_free) begin
          em_go   = 1'b1;
          em_node = icol_q;
          em_pcol = stat.top_col;
          em_last = !last_q;
          state_d = last_q ? ST_FLUSH : ST_FINISH;
        end
      end

      ST_FLUSH: begin
        if (stat.count != '0) begin
          r_d     = stat.top_col;
          cmd.pop = 1'b1;
          state_d = ST_FCHAIN;
        end else if (ovf_q) begin
          if (out_free) begin
            em_go   = 1'b1;
            em_zero = 1'b1;
            em_last = 1'b1;
            state_d = ST_FINISH;
          end
        end else begin
          state_d = ST_FINISH;
        end
      end

      ST_FCHAIN: begin
        if (out_free) begin
          em_go   = 1'b1;
          em_node = r_q;
          if (stat.count != '0) begin
            em_pcol = stat.top_col;
            r_d     = stat.top_col;
            cmd.pop = 1'b1;
          end else begin
            em_root = 1'b1;
            em_last = 1'b1;
            state_d = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        cmd.clear = last_q;
        state_d   = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Global index of the parent
  assign em_parent = (em_root || em_zero) ? '0
                   : GLOB_W'(base_q) + prod_q + GLOB_W'(em_pcol);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      pitch_q     <= '0;
      row_q       <= '0;
      col_q       <= '0;
      cfg_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cfg_seen_q <= cfg_we_i;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_BASE_OFFSET: base_q  <= cfg_data_i[BASE_W-1:0];
          REG_ROW_PITCH:   pitch_q <= cfg_data_i[PITCH_W-1:0];
          default: ;
        endcase
      end
      // Advance the column on each pixel that fits the row
      if (accept && (col_q != CNT_W'(LINE_MAX))) begin
        col_q <= col_q + CNT_W'(1);
      end else if (state_q == ST_FINISH && last_q) begin
        col_q <= '0;
        row_q <= row_q + ROW_W'(1);
      end
      if (em_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= GLOB_W'(row_q * pitch_q);
    r_q    <= r_d;
    if (accept) begin
      pix_q  <= pixel_i[LVL_W-1:0];
      last_q <= last_pixel_i;
      ovf_q  <= (col_q == CNT_W'(LINE_MAX));
      icol_q <= col_q[COL_W-1:0];
    end
    if (em_go) begin
      out_node_q   <= NODE_W'(em_node);
      out_parent_q <= em_parent;
      out_root_q   <= em_root;
      out_err_q    <= ovf_q;
      out_last_q   <= em_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign node_column_o    = out_node_q;
  assign parent_global_o  = out_parent_q;
  assign is_root_o        = out_root_q;
  assign overflow_error_o = out_err_q;
  assign last_of_run_o    = out_last_q;

endmodule

// ===== rtl/mtrb_checker.sv =====
// Port-level checks for the max-tree row builder, attached by bind.
// Depends on mtrb_pkg for port widths; binds to max_tree_row_builder.
module mtrb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [mtrb_pkg::NODE_W-1:0]   node_column_o,
  input logic [mtrb_pkg::GLOB_W-1:0]   parent_global_o,
  input logic                          is_root_o,
  input logic                          overflow_error_o,
  input logic                          last_of_run_o
);
  import mtrb_pkg::*;

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(node_column_o)
      && $stable(parent_global_o) && $stable(is_root_o) && $stable(overflow_error_o)
      && $stable(last_of_run_o))
    else $error("result item changed while stalled");

  // A root has no parent
  a_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_root_o |-> parent_global_o == '0)
    else $error("root item carries a parent index");

  // The root always closes the run of its row-ending pixel
  a_root_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_root_o |-> last_of_run_o)
    else $error("root item not marked last of run");

  // Drop ready after taking an item: one item in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted while busy");

endmodule

bind max_tree_row_builder mtrb_checker u_mtrb_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .node_column_o    (node_column_o),
  .parent_global_o  (parent_global_o),
  .is_root_o        (is_root_o),
  .overflow_error_o (overflow_error_o),
  .last_of_run_o    (last_of_run_o)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for max_tree_row_builder: pixel rows in, parent links out.
// Depends on mtrb_pkg and the block's RTL; a built-in predictor gives the expected links.
module tb_top;
  import mtrb_pkg::*;

  localparam int HOLD_OFF_CYCLES = 150;
  localparam int SETTLE_CYCLES   = 12;
  localparam int DRAIN_CYCLES    = 20;
  localparam int STALL_LIMIT     = 2000;
  localparam int REPORT_CAP      = 40;
  localparam int DIR_LEN         = 20;

  // One parent link as it leaves the block
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [GLOB_W-1:0] parent;
    logic              is_root;
    logic              ovf_err;
    logic              run_last;
  } link_t;

  // One row of the directed table; want is used only when fixed_want is set
  typedef struct packed {
    logic [PIX_IN_W-1:0] pix;
    logic                lst;
    logic                fixed_want;
    link_t               want;
  } dir_row_t;

  typedef enum int {SHAPE_NOISE, SHAPE_PLATEAU, SHAPE_RISE, SHAPE_FALL} row_shape_e;

  localparam link_t LINK_NONE  = '0;
  localparam link_t ROOT_ALONE = '{node: '0, parent: '0, is_root: 1'b1, ovf_err: 1'b0,
                                   run_last: 1'b1};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [PIX_IN_W-1:0]  pixel_i;
  logic                 last_pixel_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [NODE_W-1:0]    node_column_o;
  logic [GLOB_W-1:0]    parent_global_o;
  logic                 is_root_o;
  logic                 overflow_error_o;
  logic                 last_of_run_o;

  max_tree_row_builder u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pixel_i          (pixel_i),
    .last_pixel_i     (last_pixel_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .node_column_o    (node_column_o),
    .parent_global_o  (parent_global_o),
    .is_root_o        (is_root_o),
    .overflow_error_o (overflow_error_o),
    .last_of_run_o    (last_of_run_o)
  );

  // Directed rows, written against base 0 and pitch 0
  dir_row_t dir_tab [DIR_LEN] = '{
    // single-pixel rows at both level extremes
    '{8'h00, 1'b1, 1'b1, ROOT_ALONE},
    '{8'hFF, 1'b1, 1'b1, ROOT_ALONE},
    // rising row, flushed into a chain
    '{8'h01, 1'b0, 1'b0, LINK_NONE},
    '{8'h80, 1'b0, 1'b0, LINK_NONE},
    '{8'hFE, 1'b1, 1'b0, LINK_NONE},
    // equal level links to the standing root
    '{8'h55, 1'b0, 1'b0, LINK_NONE},
    '{8'h55, 1'b1, 1'b0, LINK_NONE},
    // falling row, each pixel unstacks the previous root
    '{8'hAA, 1'b0, 1'b0, LINK_NONE},
    '{8'h55, 1'b0, 1'b0, LINK_NONE},
    '{8'h00, 1'b1, 1'b0, LINK_NONE},
    // unstack that lands on an equal level: two links from one pixel
    '{8'h10, 1'b0, 1'b0, LINK_NONE},
    '{8'h40, 1'b0, 1'b0, LINK_NONE},
    '{8'h10, 1'b0, 1'b0, LINK_NONE},
    '{8'h20, 1'b1, 1'b0, LINK_NONE},
    // deep unstack into a new root
    '{8'h10, 1'b0, 1'b0, LINK_NONE},
    '{8'h20, 1'b0, 1'b0, LINK_NONE},
    '{8'h30, 1'b0, 1'b0, LINK_NONE},
    '{8'h40, 1'b0, 1'b0, LINK_NONE},
    '{8'h18, 1'b1, 1'b0, LINK_NONE},
    '{8'h7F, 1'b1, 1'b1, ROOT_ALONE}
  };

  // Predictor state and configuration copy
  logic [COL_W-1:0]   mt_col [LINE_MAX];
  logic [LVL_W-1:0]   mt_lvl [LINE_MAX];
  int                 mt_depth;
  int                 mt_column;
  logic [ROW_W-1:0]   mt_row;
  logic [BASE_W-1:0]  base_reg;
  logic [PITCH_W-1:0] pitch_reg;
  link_t              run_links [$];
  logic               run_ovf;

  link_t pending_links [$];
  int    mismatch_count;
  int    pixels_sent;
  bit    idle_on;
  bit    hold_off_due;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Append one link to the links of the current pixel
  function automatic void emit_link(input logic [COL_W-1:0] node,
                                    input logic [COL_W-1:0] pcol, input logic root);
    link_t l;
    l.node     = node;
    l.parent   = root ? '0 : 32'(base_reg) + 32'(mt_row) * 32'(pitch_reg) + 32'(pcol);
    l.is_root  = root;
    l.ovf_err  = run_ovf;
    l.run_last = 1'b0;
    run_links.push_back(l);
  endfunction

  function automatic void push_root(input logic [COL_W-1:0] col, input logic [LVL_W-1:0] lvl);
    if (mt_depth < LINE_MAX) begin
      mt_col[mt_depth] = col;
      mt_lvl[mt_depth] = lvl;
      mt_depth++;
    end
  endfunction

  // Work out the links caused by one pixel and advance the row state
  function automatic void predict_links(input logic [PIX_IN_W-1:0] pixel, input logic row_end);
    logic [LVL_W-1:0] lvl;
    logic [COL_W-1:0] here;
    logic [COL_W-1:0] r;
    logic [COL_W-1:0] p;
    lvl = pixel[PIXEL_BITS-1:0];
    run_links.delete();
    run_ovf = 1'b0;
    if (mt_column >= LINE_MAX) begin
      run_ovf = 1'b1;
    end else begin
      here = mt_column[COL_W-1:0];
      if (mt_depth == 0 || mt_lvl[mt_depth-1] < lvl) begin
        push_root(here, lvl);
      end else if (mt_lvl[mt_depth-1] == lvl) begin
        emit_link(here, mt_col[mt_depth-1], 1'b0);
      end else begin
        // unstack every higher root into a chain
        mt_depth--;
        r = mt_col[mt_depth];
        while (mt_depth > 0 && mt_lvl[mt_depth-1] > lvl) begin
          mt_depth--;
          p = mt_col[mt_depth];
          emit_link(r, p, 1'b0);
          r = p;
        end
        if (mt_depth == 0 || mt_lvl[mt_depth-1] < lvl) begin
          emit_link(r, here, 1'b0);
          push_root(here, lvl);
        end else begin
          emit_link(r, mt_col[mt_depth-1], 1'b0);
          emit_link(here, mt_col[mt_depth-1], 1'b0);
        end
      end
      mt_column++;
    end
    // row end: flush the stack, the bottom entry becomes the root
    if (row_end) begin
      if (mt_depth > 0) begin
        mt_depth--;
        r = mt_col[mt_depth];
        while (mt_depth > 0) begin
          mt_depth--;
          p = mt_col[mt_depth];
          emit_link(r, p, 1'b0);
          r = p;
        end
        emit_link(r, '0, 1'b1);
      end
      mt_depth  = 0;
      mt_column = 0;
      mt_row++;
    end
    // a dropped pixel with nothing else to say gives a bare error item
    if (run_ovf && run_links.size() == 0) begin
      emit_link('0, '0, 1'b1);
      run_links[0].is_root = 1'b0;
    end
    if (run_links.size() > 0) run_links[run_links.size()-1].run_last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < REPORT_CAP)
      $display("%0t ns  %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offer one pixel, hold it until accepted, then queue its links
  task automatic send_pixel(input logic [PIX_IN_W-1:0] pix, input logic lst,
                            input logic fixed_want, input link_t want);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    pixel_i      <= pix;
    last_pixel_i <= lst;
    in_valid_i   <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_links(pix, lst);
    if (fixed_want) begin
      pending_links.push_back(want);
    end else begin
      foreach (run_links[k]) pending_links.push_back(run_links[k]);
    end
    pixels_sent++;
  endtask

  task automatic send_row(input int len, input row_shape_e shape);
    int               c;
    logic [LVL_W-1:0] floor_lvl;
    logic [LVL_W-1:0] pix;
    floor_lvl = 8'($urandom_range(0, 252));
    for (c = 0; c < len; c++) begin
      case (shape)
        SHAPE_PLATEAU: pix = floor_lvl + 8'($urandom_range(0, 3));
        SHAPE_RISE:    pix = 8'(c * 4 + $urandom_range(0, 3));
        SHAPE_FALL:    pix = 8'(255 - c * 4 - $urandom_range(0, 3));
        default:       pix = 8'($urandom_range(0, 255));
      endcase
      send_pixel(pix, c == len - 1, 1'b0, LINK_NONE);
    end
  endtask

  // Short rows of random shape until the item budget is used
  task automatic send_rows(input int budget);
    int stop_at;
    stop_at = pixels_sent + budget;
    while (pixels_sent < stop_at)
      send_row($urandom_range(1, 10), row_shape_e'($urandom_range(0, 3)));
  endtask

  // Drop valid, wait for every link, then let any link-free pixel finish
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_links.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers; junk in the unused data bits of the pitch write
  task automatic set_config(input logic [BASE_W-1:0] base, input logic [PITCH_W-1:0] pitch);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_BASE_OFFSET;
    cfg_data_i  <= CFG_W'(base);
    @(posedge clk_i);
    cfg_index_i <= REG_ROW_PITCH;
    cfg_data_i  <= CFG_W'({$urandom(), pitch});
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    base_reg  = base;
    pitch_reg = pitch;
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    out_ready_i <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare each delivered item with the oldest expected link
  always @(posedge clk_i) begin : link_check
    link_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_links.size() == 0) begin
        report_mismatch("item with no link pending, node", 32'(node_column_o), '0);
      end else begin
        want = pending_links.pop_front();
        if (node_column_o != want.node)
          report_mismatch("node_column", 32'(node_column_o), 32'(want.node));
        if (parent_global_o != want.parent)
          report_mismatch("parent_global", parent_global_o, want.parent);
        if (is_root_o != want.is_root)
          report_mismatch("is_root", 32'(is_root_o), 32'(want.is_root));
        if (overflow_error_o != want.ovf_err)
          report_mismatch("overflow_error", 32'(overflow_error_o), 32'(want.ovf_err));
        if (last_of_run_o != want.run_last)
          report_mismatch("last_of_run", 32'(last_of_run_o), 32'(want.run_last));
      end
    end
  end

  // Watchdog: end the run after too many cycles with no item moving
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[max_tree_row_builder] ERROR");
    $finish;
  end

  initial begin : stimulus
    int i;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= REG_BASE_OFFSET;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    pixel_i      <= '0;
    last_pixel_i <= 1'b0;
    mt_depth       = 0;
    mt_column      = 0;
    mt_row         = '0;
    base_reg       = '0;
    pitch_reg      = '0;
    mismatch_count = 0;
    pixels_sent    = 0;
    idle_on        = 1'b1;
    hold_off_due   = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows on the reset configuration
    for (i = 0; i < DIR_LEN; i++)
      send_pixel(dir_tab[i].pix, dir_tab[i].lst, dir_tab[i].fixed_want, dir_tab[i].want);

    // top of both registers, with a long receiver hold-off
    wait_idle();
    set_config({BASE_W{1'b1}}, {PITCH_W{1'b1}});
    hold_off_due = 1'b1;
    send_rows(30);

    // bottom of both registers; a full-length rising row fills the stack
    wait_idle();
    set_config('0, '0);
    send_row(LINE_MAX, SHAPE_RISE);
    send_rows(10);

    // random registers; an over-long row, dropped pixel then dropped last pixel
    wait_idle();
    set_config(31'($urandom()), 16'($urandom()));
    send_row(LINE_MAX + 2, SHAPE_NOISE);
    send_rows(10);

    // closing stretch with no idling on either side
    wait_idle();
    idle_on = 1'b0;
    set_config(31'($urandom()), 16'($urandom()));
    send_rows(20);

    in_valid_i <= 1'b0;
    while (pending_links.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("[max_tree_row_builder] OK");
    else
      $display("[max_tree_row_builder] ERROR");
    $finish;
  end

endmodule

// ===== max_tree_row_builder.f =====
rtl/mtrb_pkg.sv
rtl/mtrb_stack.sv
rtl/max_tree_row_builder.sv
rtl/mtrb_checker.sv
tb/sv/tb_top.sv
